/* src/lru_pkg.sv */
package lru_pkg;
  localparam int unsigned EntriesDef = 16;
  localparam int unsigned DataW = 32;
  localparam int unsigned CapW = 5;
  localparam logic [CapW-1:0] CapReset = 5'd16;
  localparam int unsigned QDepth = 2;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [DataW-1:0] key;
    logic [DataW-1:0] value;
  } req_t;
endpackage

/* src/lru_key_value_cache.sv */
// Fully associative key-value cache with least-recently-used replacement.
// Requests enter a two-beat queue; the back end executes one request per cycle
// (associative match, rank update and replacement over all entries at once),
// so throughput is one beat per clock unless out_stall_i holds a get result.
// A get yields one registered result beat, a put none. The user must write the
// capacity register through its own valid/ready port while idle (not enforced).
module lru_key_value_cache import lru_pkg::*; #(
  parameter int unsigned Entries = EntriesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CapW-1:0]  cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             operation_i,
  input  logic [DataW-1:0] key_i,
  input  logic [DataW-1:0] value_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             found_o,
  output logic [DataW-1:0] read_value_o
);
  logic [CapW-1:0] cap_q;
  req_t            in_req, req;
  logic            req_valid, req_take;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= CapReset;
    else if (cfg_valid_i) cap_q <= cfg_data_i;
  end

  assign in_req = '{op: op_e'(operation_i), key: key_i, value: value_i};

  lru_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .in_req_i(in_req), .req_valid_o(req_valid), .req_take_i(req_take), .req_o(req)
  );

  lru_back #(.Entries(Entries)) u_back (
    .clk_i, .rst_ni, .capacity_i(cap_q),
    .req_valid_i(req_valid), .req_take_o(req_take), .req_i(req),
    .out_valid_o, .out_stall_i, .found_o, .read_value_o
  );
endmodule

/* src/lru_front.sv */
// request queue: takes beats and hands them to the back end in order
module lru_front import lru_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic req_valid_o,
  input  logic req_take_i,
  output req_t req_o
);
  req_t       mem_q [QDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_stall_o  = (cnt_q == 2'(QDepth));
  assign push        = in_valid_i && !in_stall_o;
  assign req_valid_o = (cnt_q != 2'd0);
  assign pop         = req_valid_o && req_take_i;
  assign req_o       = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

/* src/lru_back.sv */
// entry array: associative match, rank update, replacement, result register
module lru_back import lru_pkg::*; #(
  parameter int unsigned Entries = EntriesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CapW-1:0]  capacity_i,
  input  logic             req_valid_i,
  output logic             req_take_o,
  input  req_t             req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             found_o,
  output logic [DataW-1:0] read_value_o
);
  localparam int unsigned AW = $clog2(Entries);
  localparam int unsigned NW = $clog2(Entries + 1);

  logic [Entries-1:0] vld_q, vld_d;
  logic [DataW-1:0]   key_q [Entries];
  logic [DataW-1:0]   val_q [Entries];
  logic [AW-1:0]      age_q [Entries];
  logic [AW-1:0]      age_d [Entries];
  logic [NW-1:0]      cnt_q, cnt_d;
  logic               ov_q;
  logic               fnd_q;
  logic [DataW-1:0]   rv_q;

  logic [Entries-1:0] hit, old, v1;
  logic               any_hit, any_old, any_free, evict;
  logic [AW-1:0]      hit_a, old_a, free_a, top;
  logic [NW-1:0]      cnt1, effcap;
  logic [AW-1:0]      a1 [Entries];
  logic               go;

  assign req_take_o = !ov_q || !out_stall_i;
  assign go = req_valid_i && req_take_o;

  always_comb begin
    if (capacity_i == '0) effcap = NW'(1);
    else if (32'(capacity_i) > Entries) effcap = NW'(Entries);
    else effcap = NW'(capacity_i);
  end

  always_comb begin
    any_hit = 1'b0; hit_a = '0;
    for (int i = 0; i < Entries; i++) begin
      hit[i] = vld_q[i] && key_q[i] == req_i.key;
      if (hit[i] && !any_hit) begin any_hit = 1'b1; hit_a = AW'(i); end
    end
    // ranks after removing the matched slot on a put
    v1   = vld_q;
    cnt1 = cnt_q;
    for (int i = 0; i < Entries; i++) a1[i] = age_q[i];
    if (req_i.op == OP_PUT && any_hit) begin
      v1[hit_a] = 1'b0;
      cnt1 = cnt_q - NW'(1);
      for (int i = 0; i < Entries; i++)
        if (age_q[i] > age_q[hit_a]) a1[i] = age_q[i] - AW'(1);
    end
    // least recent slot holds rank count-1
    top = AW'(cnt1 - NW'(1));
    any_old = 1'b0; old_a = '0;
    for (int i = 0; i < Entries; i++) begin
      old[i] = v1[i] && a1[i] == top;
      if (old[i] && !any_old) begin any_old = 1'b1; old_a = AW'(i); end
    end
    evict = (cnt1 >= effcap) && any_old && cnt1 != '0;
    if (evict) begin
      v1[old_a] = 1'b0;
      cnt1 = cnt1 - NW'(1);
    end
    any_free = 1'b0; free_a = '0;
    for (int i = 0; i < Entries; i++)
      if (!v1[i] && !any_free) begin any_free = 1'b1; free_a = AW'(i); end

    vld_d = vld_q;
    cnt_d = cnt_q;
    for (int i = 0; i < Entries; i++) age_d[i] = age_q[i];
    if (req_i.op == OP_GET) begin
      if (any_hit)
        for (int i = 0; i < Entries; i++) begin
          if (i == 32'(hit_a)) age_d[i] = '0;
          else if (age_q[i] < age_q[hit_a]) age_d[i] = age_q[i] + AW'(1);
        end
    end else begin
      // evicted slot is the oldest, so no other rank moves on eviction
      for (int i = 0; i < Entries; i++) age_d[i] = a1[i] + AW'(1);
      age_d[free_a] = '0;
      v1[free_a] = 1'b1;
      vld_d = v1;
      cnt_d = cnt1 + NW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      for (int i = 0; i < Entries; i++) age_q[i] <= age_d[i];
      if (req_i.op == OP_PUT) begin
        key_q[free_a] <= req_i.key;
        val_q[free_a] <= req_i.value;
      end else begin
        fnd_q <= any_hit;
        rv_q  <= any_hit ? val_q[hit_a] : '1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (go) begin
        vld_q <= vld_d;
        cnt_q <= cnt_d;
      end
      if (go) ov_q <= (req_i.op == OP_GET);
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  assign out_valid_o  = ov_q;
  assign found_o      = fnd_q;
  assign read_value_o = rv_q;
endmodule
